FILE: design/lqrbc_pkg.sv
// Shared constants, codes and fixed-point helpers for the LQR balance controller.
package lqrbc_pkg;

    // Window and filter geometry
    localparam int WINDOW    = 13;
    localparam int NTAPS     = 13;
    localparam int NT_USED   = (WINDOW < NTAPS) ? WINDOW : NTAPS;
    localparam int W_AW      = $clog2(WINDOW);
    localparam int W_FW      = $clog2(WINDOW + 1);
    localparam int TAP_KW    = $clog2(NT_USED);

    localparam logic [W_AW-1:0]   WIN_LAST = W_AW'(WINDOW - 1);
    localparam logic [W_FW-1:0]   WIN_FULL = W_FW'(WINDOW);
    localparam logic [TAP_KW-1:0] TAP_LAST = TAP_KW'(NT_USED - 1);

    // Scaling constants
    localparam logic signed [16:0] PULLEY_R     = 17'sd1670;
    localparam logic signed [63:0] POS_LIMIT    = 64'sd19661;
    localparam logic signed [63:0] CUR_LIMIT    = 64'sd589824;
    localparam logic signed [31:0] DEG2RAD_Q32  = 32'sd74961321;
    localparam logic signed [63:0] RATE_DB      = 64'sd42950;
    localparam logic signed [63:0] TORQUE_MAX   = 64'sd327680;
    localparam logic signed [63:0] CMD_LIM      = 64'sh0000_4000_0000_0000;
    localparam logic signed [63:0] SUM_LIM      = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] S32_MAX      = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN      = -64'sd2147483648;
    localparam logic signed [63:0] S64_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN      = 64'sh8000_0000_0000_0000;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_POS_OFF   = 3'd1;
    localparam logic [2:0] CFG_G_CPOS    = 3'd2;
    localparam logic [2:0] CFG_G_CVEL    = 3'd3;
    localparam logic [2:0] CFG_G_PANG    = 3'd4;
    localparam logic [2:0] CFG_G_PRATE   = 3'd5;
    localparam logic [2:0] CFG_PD_KP     = 3'd6;
    localparam logic [2:0] CFG_PD_KD     = 3'd7;

    localparam logic signed [31:0] PD_KP_RST = 32'sd655360;
    localparam logic signed [31:0] PD_KD_RST = 32'sd65536;

    // Control modes
    localparam logic MODE_TORQUE = 1'b0;
    localparam logic MODE_PD     = 1'b1;

    // Trip causes
    localparam logic [1:0] TRIP_NONE     = 2'd0;
    localparam logic [1:0] TRIP_CURRENT  = 2'd1;
    localparam logic [1:0] TRIP_POSITION = 2'd2;

    typedef logic signed [22:0] t_tap;

    // Savitzky-Golay derivative taps, newest sample first, Q6.16 scale
    localparam t_tap SG_TAPS [NTAPS] = '{
        -23'sd1545377, 23'sd900220, 23'sd2152344, 23'sd2449689, 23'sd2030950,
        23'sd1134823, 23'sd0, -23'sd1134823, -23'sd2030950, -23'sd2449689,
        -23'sd2152344, -23'sd900220, 23'sd1545377
    };

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Round to nearest, halves upward, after clamping to the working range
    function automatic logic signed [63:0] rshr16(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = clamp64(v, SUM_LIM);
        return (c + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [63:0] rshr32(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = clamp64(v, SUM_LIM);
        return (c + 64'sd2147483648) >>> 32;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX) begin
            return S32_MAX[31:0];
        end else if (v < S32_MIN) begin
            return S32_MIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

endpackage

FILE: design/lqrbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lqrbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/lqr_balance_controller_step.sv
// LQR balance controller: pole-angle window in RAM, shared-multiplier sequencer.
//
// Usage: one input beat per control tick on the i_in_valid / o_in_stall channel carries
// motor angle, speed, current, pole angle in degrees and an angle-valid flag. Each tick
// gives exactly one result beat on o_out_valid / i_out_stall: clamped torque, trip flag
// and cause, cart position and velocity, negated pole angle and negated pole rate.
// Configuration writes use i_cfg_valid / o_cfg_ready (always ready) with a 3-bit register
// index and 32-bit data; write only while no tick is in flight.
// Timing: the tick length is set by the tap loop, which reads one window entry a cycle
// from the RAM port and feeds one shared 32x32 multiplier that also forms the feedback
// and PD products; PD mode adds the S_P1 to S_P3 states. The result is registered into
// the output register from the S_OUT state.
// A finished result waits in the output register while the next tick is accepted; if
// the receiver still stalls when that tick completes, the sequencer holds in its last
// state and o_in_stall stays high.
// Reset: synchronous, active low. Clears the sequencer, the trip latch, the window fill
// count (unfilled window entries read as zero) and loads register defaults.
module lqr_balance_controller_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_motor_angle,
    input  logic signed [31:0] i_motor_speed,
    input  logic signed [31:0] i_motor_current,
    input  logic signed [31:0] i_pole_angle_deg,
    input  logic               i_angle_valid,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [19:0] o_torque,
    output logic               o_tripped,
    output logic [1:0]         o_trip_cause,
    output logic signed [31:0] o_cart_position,
    output logic signed [31:0] o_cart_velocity,
    output logic signed [31:0] o_pole_angle,
    output logic signed [31:0] o_pole_rate,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW = lqrbc_pkg::W_AW;
    localparam int FW = lqrbc_pkg::W_FW;
    localparam int KW = lqrbc_pkg::TAP_KW;

    // Sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RAD  = 4'd1;
    localparam logic [3:0] S_PUSH = 4'd2;
    localparam logic [3:0] S_MAC  = 4'd3;
    localparam logic [3:0] S_RATE = 4'd4;
    localparam logic [3:0] S_D1   = 4'd5;
    localparam logic [3:0] S_D2   = 4'd6;
    localparam logic [3:0] S_D3   = 4'd7;
    localparam logic [3:0] S_D4   = 4'd8;
    localparam logic [3:0] S_TRIP = 4'd9;
    localparam logic [3:0] S_P1   = 4'd10;
    localparam logic [3:0] S_P2   = 4'd11;
    localparam logic [3:0] S_P3   = 4'd12;
    localparam logic [3:0] S_T1   = 4'd13;
    localparam logic [3:0] S_T2   = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Configuration registers
    logic               r_mode;
    logic signed [31:0] r_pos_off;
    logic signed [31:0] r_g_cpos;
    logic signed [31:0] r_g_cvel;
    logic signed [31:0] r_g_pang;
    logic signed [31:0] r_g_prate;
    logic signed [31:0] r_pd_kp;
    logic signed [31:0] r_pd_kd;

    // Latched input beat
    logic signed [31:0] r_ang;
    logic signed [31:0] r_spd;
    logic signed [31:0] r_cur;
    logic signed [31:0] r_deg;
    logic               r_avld;

    // Window bookkeeping
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      n_head;
    logic [FW-1:0]      r_fill;
    logic signed [31:0] r_newest;
    logic [AW-1:0]      r_raddr;
    logic [KW-1:0]      r_k;
    logic [KW-1:0]      r_k1;
    logic [KW-1:0]      r_k2;
    logic               r_issue;
    logic               r_v1;
    logic               r_v2;

    // Datapath
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_pos_raw;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_pang;
    logic signed [31:0] r_prate;
    logic signed [63:0] r_dot;
    logic signed [31:0] r_err;
    logic signed [63:0] r_cmd;
    logic signed [47:0] r_u;
    logic signed [19:0] r_torque;
    logic               r_trip;
    logic [1:0]         r_trip_cause;

    // Output register
    logic               r_out_valid;
    logic signed [19:0] r_out_torque;
    logic               r_out_tripped;
    logic [1:0]         r_out_cause;
    logic signed [31:0] r_out_pos;
    logic signed [31:0] r_out_vel;
    logic signed [31:0] r_out_pang;
    logic signed [31:0] r_out_prate;

    logic               in_accept;
    logic               out_load;
    logic [31:0]        rd_data;
    logic signed [31:0] win_val;
    logic signed [63:0] n_rad_full;
    logic signed [31:0] n_rad;
    logic signed [32:0] n_diff;
    logic signed [63:0] n_pos_raw;
    logic signed [63:0] n_vel_full;
    logic signed [63:0] n_acc_db;
    logic signed [31:0] n_rate;
    logic signed [63:0] n_dotc;
    logic signed [31:0] n_xdes;
    logic signed [32:0] n_abs_cur;
    logic signed [63:0] n_abs_pos;
    logic signed [63:0] n_u;
    logic signed [63:0] n_t;
    lqrbc_pkg::t_tap    tap;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Pole-angle window store
    lqrbc_ram #(
        .WIDTH (32),
        .DEPTH (lqrbc_pkg::WINDOW)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_PUSH),
        .i_wr_addr (n_head),
        .i_wr_data (n_rad),
        .i_rd_en   ((r_state == S_MAC) && r_issue),
        .i_rd_addr (r_raddr),
        .o_rd_data (rd_data)
    );

    // Form per-step values
    always_comb begin
        n_head     = (r_head == lqrbc_pkg::WIN_LAST) ? '0 : r_head + 1'b1;
        n_rad_full = lqrbc_pkg::rshr32(r_prod);
        n_rad      = r_avld ? n_rad_full[31:0] : r_newest;
        n_diff     = 33'(r_ang) - 33'(r_pos_off);
        n_pos_raw  = lqrbc_pkg::rshr16(64'(n_diff) * 64'(lqrbc_pkg::PULLEY_R));
        n_vel_full = lqrbc_pkg::rshr16(64'(r_spd) * 64'(lqrbc_pkg::PULLEY_R));
        tap        = lqrbc_pkg::SG_TAPS[r_k1];
        win_val    = (FW'(r_k1) < r_fill) ? $signed(rd_data) : 32'sd0;
        n_acc_db   = ((r_acc > -lqrbc_pkg::RATE_DB) && (r_acc < lqrbc_pkg::RATE_DB))
                     ? 64'sd0 : r_acc;
        n_rate     = lqrbc_pkg::sat32(lqrbc_pkg::rshr16(n_acc_db));
        n_dotc     = lqrbc_pkg::clamp64(r_dot, lqrbc_pkg::SUM_LIM);
        n_xdes     = lqrbc_pkg::sat32(lqrbc_pkg::rshr16(-n_dotc));
        n_abs_cur  = r_cur[31] ? -33'(r_cur) : 33'(r_cur);
        n_abs_pos  = r_pos_raw[63] ? -r_pos_raw : r_pos_raw;
        n_u        = lqrbc_pkg::clamp64(lqrbc_pkg::rshr16(r_cmd), lqrbc_pkg::CMD_LIM);
        n_t        = lqrbc_pkg::clamp64(
                         lqrbc_pkg::rshr16(64'(r_u) * 64'(lqrbc_pkg::PULLEY_R)),
                         lqrbc_pkg::TORQUE_MAX);
    end

    // Steer the shared multiplier
    always_comb begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        case (r_state)
            S_RAD: begin
                mul_a = r_deg;
                mul_b = lqrbc_pkg::DEG2RAD_Q32;
            end
            S_MAC: begin
                mul_a = win_val;
                mul_b = {{9{tap[22]}}, tap};
            end
            S_RATE: begin
                mul_a = r_g_cpos;
                mul_b = r_pos;
            end
            S_D1: begin
                mul_a = r_g_cvel;
                mul_b = r_vel;
            end
            S_D2: begin
                mul_a = r_g_pang;
                mul_b = r_pang;
            end
            S_D3: begin
                mul_a = r_g_prate;
                mul_b = r_prate;
            end
            S_P1: begin
                mul_a = r_pd_kp;
                mul_b = r_err;
            end
            S_P2: begin
                mul_a = r_pd_kd;
                mul_b = r_vel;
            end
            default: begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: n_state = in_accept ? S_RAD : S_IDLE;
            S_RAD:  n_state = S_PUSH;
            S_PUSH: n_state = S_MAC;
            S_MAC:  n_state = (r_v2 && (r_k2 == lqrbc_pkg::TAP_LAST)) ? S_RATE : S_MAC;
            S_RATE: n_state = S_D1;
            S_D1:   n_state = S_D2;
            S_D2:   n_state = S_D3;
            S_D3:   n_state = S_D4;
            S_D4:   n_state = S_TRIP;
            S_TRIP: n_state = (r_mode == lqrbc_pkg::MODE_PD) ? S_P1 : S_T1;
            S_P1:   n_state = S_P2;
            S_P2:   n_state = S_P3;
            S_P3:   n_state = S_T1;
            S_T1:   n_state = S_T2;
            S_T2:   n_state = S_OUT;
            S_OUT:  n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration, window bookkeeping, trip latch and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= lqrbc_pkg::MODE_TORQUE;
            r_pos_off    <= '0;
            r_g_cpos     <= '0;
            r_g_cvel     <= '0;
            r_g_pang     <= '0;
            r_g_prate    <= '0;
            r_pd_kp      <= lqrbc_pkg::PD_KP_RST;
            r_pd_kd      <= lqrbc_pkg::PD_KD_RST;
            r_head       <= lqrbc_pkg::WIN_LAST;
            r_fill       <= '0;
            r_newest     <= '0;
            r_issue      <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_trip       <= 1'b0;
            r_trip_cause <= lqrbc_pkg::TRIP_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // take configuration beats
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lqrbc_pkg::CFG_MODE:    r_mode    <= i_cfg_data[0];
                    lqrbc_pkg::CFG_POS_OFF: r_pos_off <= $signed(i_cfg_data);
                    lqrbc_pkg::CFG_G_CPOS:  r_g_cpos  <= $signed(i_cfg_data);
                    lqrbc_pkg::CFG_G_CVEL:  r_g_cvel  <= $signed(i_cfg_data);
                    lqrbc_pkg::CFG_G_PANG:  r_g_pang  <= $signed(i_cfg_data);
                    lqrbc_pkg::CFG_G_PRATE: r_g_prate <= $signed(i_cfg_data);
                    lqrbc_pkg::CFG_PD_KP:   r_pd_kp   <= $signed(i_cfg_data);
                    lqrbc_pkg::CFG_PD_KD:   r_pd_kd   <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // push the new angle and start the tap loop
            if (r_state == S_PUSH) begin
                r_head   <= n_head;
                r_newest <= n_rad;
                if (r_fill != lqrbc_pkg::WIN_FULL) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_issue  <= 1'b1;
                r_v1     <= 1'b0;
                r_v2     <= 1'b0;
            end else if (r_state == S_MAC) begin
                if (r_issue && (r_k == lqrbc_pkg::TAP_LAST)) begin
                    r_issue <= 1'b0;
                end
                r_v1 <= r_issue;
                r_v2 <= r_v1;
            end

            // latch a trip, current first
            if ((r_state == S_TRIP) && !r_trip) begin
                if (64'(n_abs_cur) > lqrbc_pkg::CUR_LIMIT) begin
                    r_trip       <= 1'b1;
                    r_trip_cause <= lqrbc_pkg::TRIP_CURRENT;
                end else if (n_abs_pos > lqrbc_pkg::POS_LIMIT) begin
                    r_trip       <= 1'b1;
                    r_trip_cause <= lqrbc_pkg::TRIP_POSITION;
                end
            end

            // hold or drop the result beat
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);

        if (in_accept) begin
            r_ang  <= i_motor_angle;
            r_spd  <= i_motor_speed;
            r_cur  <= i_motor_current;
            r_deg  <= i_pole_angle_deg;
            r_avld <= i_angle_valid;
        end

        unique case (r_state)
            S_PUSH: begin
                r_raddr   <= n_head;
                r_k       <= '0;
                r_acc     <= '0;
                r_pos_raw <= n_pos_raw;
                r_pos     <= lqrbc_pkg::sat32(n_pos_raw);
                r_vel     <= lqrbc_pkg::sat32(n_vel_full);
                r_pang    <= lqrbc_pkg::sat32(-64'(n_rad));
            end
            S_MAC: begin
                // advance the read pointer towards older entries
                if (r_issue) begin
                    r_raddr <= (r_raddr == '0) ? lqrbc_pkg::WIN_LAST : r_raddr - 1'b1;
                    r_k     <= r_k + 1'b1;
                end
                r_k1 <= r_k;
                r_k2 <= r_k1;
                if (r_v2) begin
                    r_acc <= r_acc + r_prod;
                end
            end
            S_RATE: r_prate <= lqrbc_pkg::sat32(-64'(n_rate));
            S_D1:   r_dot   <= r_prod;
            S_D2, S_D3, S_D4: r_dot <= lqrbc_pkg::sat_add(r_dot, r_prod);
            S_TRIP: begin
                r_cmd <= -n_dotc;
                r_err <= lqrbc_pkg::sat32(64'(n_xdes) - 64'(r_pos));
            end
            S_P2:   r_cmd    <= r_prod;
            S_P3:   r_cmd    <= lqrbc_pkg::sat_add(r_cmd, -r_prod);
            S_T1:   r_u      <= n_u[47:0];
            S_T2:   r_torque <= n_t[19:0];
            default: ;
        endcase

        if (out_load) begin
            r_out_torque  <= r_trip ? 20'sd0 : r_torque;
            r_out_tripped <= r_trip;
            r_out_cause   <= r_trip_cause;
            r_out_pos     <= r_pos;
            r_out_vel     <= r_vel;
            r_out_pang    <= r_pang;
            r_out_prate   <= r_prate;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_torque        = r_out_torque;
    assign o_tripped       = r_out_tripped;
    assign o_trip_cause    = r_out_cause;
    assign o_cart_position = r_out_pos;
    assign o_cart_velocity = r_out_vel;
    assign o_pole_angle    = r_out_pang;
    assign o_pole_rate     = r_out_prate;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the LQR balance controller step: scoreboard, stimulus and checks.
module tb_top;
    import lqrbc_pkg::*;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     SETTLE_CYCLES  = 64;
    // widest motor-angle swing about the offset that keeps the cart inside its limit
    localparam int     CALM_SPAN      = 771578;
    localparam int     CUR_MAX        = 589824;
    localparam int     SPEED_SPAN     = 1310720;
    localparam int     DEG_SPAN       = 1966080;

    localparam longint DEG_TO_RAD = 64'sd74961321;
    localparam longint DEADBAND   = 64'sd42950;
    localparam longint RADIUS     = 64'sd1670;
    localparam longint POS_TRIP   = 64'sd19661;
    localparam longint CUR_TRIP   = 64'sd589824;
    localparam longint TORQUE_CAP = 64'sd327680;
    localparam longint CMD_CAP    = 64'sh0000_4000_0000_0000;
    localparam longint WORK_CAP   = 64'sh4000_0000_0000_0000;
    localparam longint SG_COEF [13] = '{
        -64'sd1545377, 64'sd900220, 64'sd2152344, 64'sd2449689, 64'sd2030950,
        64'sd1134823, 64'sd0, -64'sd1134823, -64'sd2030950, -64'sd2449689,
        -64'sd2152344, -64'sd900220, 64'sd1545377
    };

    typedef struct packed {
        logic signed [31:0] motor_angle;
        logic signed [31:0] motor_speed;
        logic signed [31:0] motor_current;
        logic signed [31:0] pole_angle_deg;
        logic               angle_valid;
    } t_tick;

    typedef struct packed {
        logic signed [19:0] torque;
        logic               tripped;
        logic [1:0]         trip_cause;
        logic signed [31:0] cart_position;
        logic signed [31:0] cart_velocity;
        logic signed [31:0] pole_angle;
        logic signed [31:0] pole_rate;
    } t_control;

    typedef enum int {TRIP_BY_CURRENT, TRIP_BY_POSITION, TRIP_BY_BOTH} t_trip_plan;

    // Tracks controller state per accepted tick and holds the commands still due
    class t_balance_scoreboard;
        longint     window_rad [WINDOW];
        bit         trip_set;
        logic [1:0] trip_why;
        logic       pd_mode;
        longint     offset, k_pos, k_vel, k_ang, k_rate, kp, kd;
        t_control   awaiting [$];
        int         mismatches;
        int         checked;

        function new();
            foreach (window_rad[i]) window_rad[i] = 0;
            trip_set   = 1'b0;
            trip_why   = TRIP_NONE;
            pd_mode    = MODE_TORQUE;
            offset     = 0;
            k_pos      = 0;
            k_vel      = 0;
            k_ang      = 0;
            k_rate     = 0;
            kp         = 655360;   // 10.0
            kd         = 65536;    // 1.0
            mismatches = 0;
            checked    = 0;
        endfunction

        static function longint clamp_mag(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // round to nearest, halves upward, after limiting to the working range
        static function longint round_shift(longint v, int s);
            longint c;
            c = clamp_mag(v, WORK_CAP);
            return (c + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        static function longint sat_word(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        static function longint sum_sat(longint a, longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            return s;
        endfunction

        static function longint torque_of(longint cmd);
            longint u;
            u = clamp_mag(round_shift(cmd, 16), CMD_CAP);
            return clamp_mag(round_shift(u * RADIUS, 16), TORQUE_CAP);
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_MODE:    pd_mode = data[0];
                CFG_POS_OFF: offset  = longint'($signed(data));
                CFG_G_CPOS:  k_pos   = longint'($signed(data));
                CFG_G_CVEL:  k_vel   = longint'($signed(data));
                CFG_G_PANG:  k_ang   = longint'($signed(data));
                CFG_G_PRATE: k_rate  = longint'($signed(data));
                CFG_PD_KP:   kp      = longint'($signed(data));
                CFG_PD_KD:   kd      = longint'($signed(data));
                default: ;
            endcase
        endfunction

        // Advance the angle window, estimate the state and queue the command this tick yields
        function void note_tick(t_tick t);
            longint   rad, acc, rate, pos_raw, pos, vel, pang, prate, dot, torque;
            longint   xdes, err, cur_abs, pos_abs;
            t_control r;
            if (t.angle_valid)
                rad = round_shift(longint'($signed(t.pole_angle_deg)) * DEG_TO_RAD, 32);
            else
                rad = window_rad[WINDOW-1];
            for (int i = 0; i < WINDOW - 1; i++) window_rad[i] = window_rad[i+1];
            window_rad[WINDOW-1] = rad;

            acc = 0;
            for (int k = 0; k < 13 && k < WINDOW; k++)
                acc += SG_COEF[k] * window_rad[WINDOW-1-k];
            if (acc > -DEADBAND && acc < DEADBAND) acc = 0;
            rate = sat_word(round_shift(acc, 16));

            pos_raw = round_shift((longint'($signed(t.motor_angle)) - offset) * RADIUS, 16);
            pos     = sat_word(pos_raw);
            vel     = sat_word(round_shift(longint'($signed(t.motor_speed)) * RADIUS, 16));
            pang    = sat_word(-rad);
            prate   = sat_word(-rate);

            dot = k_pos * pos;
            dot = sum_sat(dot, k_vel * vel);
            dot = sum_sat(dot, k_ang * pang);
            dot = sum_sat(dot, k_rate * prate);
            dot = clamp_mag(dot, WORK_CAP);

            // current has priority over position; the latch holds until reset
            if (!trip_set) begin
                cur_abs = longint'($signed(t.motor_current));
                if (cur_abs < 0) cur_abs = -cur_abs;
                pos_abs = (pos_raw < 0) ? -pos_raw : pos_raw;
                if (cur_abs > CUR_TRIP) begin
                    trip_set = 1'b1;
                    trip_why = TRIP_CURRENT;
                end else if (pos_abs > POS_TRIP) begin
                    trip_set = 1'b1;
                    trip_why = TRIP_POSITION;
                end
            end

            torque = 0;
            if (!trip_set) begin
                if (pd_mode == MODE_TORQUE) begin
                    torque = torque_of(-dot);
                end else begin
                    xdes   = sat_word(round_shift(-dot, 16));
                    err    = sat_word(xdes - pos);
                    torque = torque_of(sum_sat(kp * err, -(kd * vel)));
                end
            end

            r.torque        = torque[19:0];
            r.tripped       = trip_set;
            r.trip_cause    = trip_why;
            r.cart_position = pos[31:0];
            r.cart_velocity = vel[31:0];
            r.pole_angle    = pang[31:0];
            r.pole_rate     = prate[31:0];
            awaiting.insert(awaiting.size(), r);
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH %s", msg);
        endfunction

        function void check_result(t_control got);
            t_control want;
            longint   w [7];
            longint   g [7];
            string    field_name [7];
            field_name = '{"torque", "tripped", "trip_cause", "cart_position",
                           "cart_velocity", "pole_angle", "pole_rate"};
            if (awaiting.size() == 0) begin
                complain("result beat arrived with no tick outstanding");
                return;
            end
            want = awaiting[0];
            awaiting.delete(0);
            checked++;
            w = '{want.torque, want.tripped, want.trip_cause, want.cart_position,
                  want.cart_velocity, want.pole_angle, want.pole_rate};
            g = '{got.torque, got.tripped, got.trip_cause, got.cart_position,
                  got.cart_velocity, got.pole_angle, got.pole_rate};
            foreach (w[i])
                if (w[i] != g[i])
                    complain($sformatf("tick %0d %s: expected %0d, got %0d",
                                       checked, field_name[i], w[i], g[i]));
        endfunction

        function int pending();
            return awaiting.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_motor_angle;
    logic signed [31:0] i_motor_speed;
    logic signed [31:0] i_motor_current;
    logic signed [31:0] i_pole_angle_deg;
    logic               i_angle_valid;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [19:0] o_torque;
    logic               o_tripped;
    logic [1:0]         o_trip_cause;
    logic signed [31:0] o_cart_position;
    logic signed [31:0] o_cart_velocity;
    logic signed [31:0] o_pole_angle;
    logic signed [31:0] o_pole_rate;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    t_balance_scoreboard sb;
    logic [31:0]        cfg_val [8];
    longint             cur_offset;
    logic signed [31:0] last_deg;
    int                 gap_pct;
    int                 stall_pct;
    int                 quiet_cycles;

    lqr_balance_controller_step i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_motor_angle    (i_motor_angle),
        .i_motor_speed    (i_motor_speed),
        .i_motor_current  (i_motor_current),
        .i_pole_angle_deg (i_pole_angle_deg),
        .i_angle_valid    (i_angle_valid),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_torque         (o_torque),
        .o_tripped        (o_tripped),
        .o_trip_cause     (o_trip_cause),
        .o_cart_position  (o_cart_position),
        .o_cart_velocity  (o_cart_velocity),
        .o_pole_angle     (o_pole_angle),
        .o_pole_rate      (o_pole_rate),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Sample beats at the rising edge: check results first, then note new ticks
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(t_control'{o_torque, o_tripped, o_trip_cause, o_cart_position,
                                           o_cart_velocity, o_pole_angle, o_pole_rate});
            if (i_in_valid && !o_in_stall)
                sb.note_tick(t_tick'{i_motor_angle, i_motor_speed, i_motor_current,
                                     i_pole_angle_deg, i_angle_valid});
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("lqr_balance_controller_step verification failed");
                $finish;
            end
        end
    end

    function automatic t_tick mk(input logic [31:0] ang, input logic [31:0] spd,
                                 input logic [31:0] cur, input logic [31:0] deg,
                                 input logic ok);
        t_tick t;
        t.motor_angle    = ang;
        t.motor_speed    = spd;
        t.motor_current  = cur;
        t.pole_angle_deg = deg;
        t.angle_valid    = ok;
        return t;
    endfunction

    // Well-formed tick: cart inside its limit, current legal, pole mostly near upright
    function automatic t_tick calm_tick();
        t_tick  t;
        longint d;
        longint a;
        int     pick;
        d = longint'($urandom_range(2 * CALM_SPAN)) - CALM_SPAN;
        a = cur_offset + d;
        if (a > 64'sd2147483647 || a < -64'sd2147483648) a = cur_offset - d;
        t.motor_angle = a[31:0];
        if ($urandom_range(99) < 80)
            t.motor_speed = int'($urandom_range(2 * SPEED_SPAN)) - SPEED_SPAN;
        else
            t.motor_speed = $urandom;
        if ($urandom_range(19) == 0)
            t.motor_current = $urandom_range(1) ? CUR_MAX : -CUR_MAX;
        else
            t.motor_current = int'($urandom_range(2 * CUR_MAX)) - CUR_MAX;
        pick = $urandom_range(99);
        if (pick < 20)
            t.pole_angle_deg = last_deg;
        else if (pick < 85)
            t.pole_angle_deg = int'($urandom_range(2 * DEG_SPAN)) - DEG_SPAN;
        else
            t.pole_angle_deg = $urandom;
        last_deg = t.pole_angle_deg;
        t.angle_valid = ($urandom_range(99) < 85);
        return t;
    endfunction

    function automatic logic [31:0] rand_gain();
        logic [31:0] g;
        g = $urandom >> $urandom_range(31, 8);
        if ($urandom_range(1)) g = -g;
        return g;
    endfunction

    function automatic void moderate_setting(input logic pd);
        cfg_val[CFG_MODE]    = ($urandom & ~32'h1) | {31'd0, pd};
        cfg_val[CFG_POS_OFF] = $urandom;
        cfg_val[CFG_G_CPOS]  = rand_gain();
        cfg_val[CFG_G_CVEL]  = rand_gain();
        cfg_val[CFG_G_PANG]  = rand_gain();
        cfg_val[CFG_G_PRATE] = rand_gain();
        cfg_val[CFG_PD_KP]   = rand_gain();
        cfg_val[CFG_PD_KD]   = rand_gain();
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_tick(input t_tick t);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_motor_angle    <= t.motor_angle;
        i_motor_speed    <= t.motor_speed;
        i_motor_current  <= t.motor_current;
        i_pole_angle_deg <= t.pole_angle_deg;
        i_angle_valid    <= t.angle_valid;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every queued command has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input int first, input int last);
        for (int i = first; i <= last; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data  <= cfg_val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(i[2:0], cfg_val[i]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cur_offset = longint'($signed(cfg_val[CFG_POS_OFF]));
    endtask

    task automatic run_calm(input int count);
        for (int n = 0; n < count; n++) send_tick(calm_tick());
    endtask

    initial begin
        t_trip_plan plan;
        t_tick      t;
        int         fails;
        string      plan_name;

        sb           = new();
        cur_offset   = 0;
        last_deg     = '0;
        gap_pct      = 31;
        stall_pct    = 56;
        foreach (cfg_val[i]) cfg_val[i] = '0;
        cfg_val[CFG_PD_KP] = 32'd655360;
        cfg_val[CFG_PD_KD] = 32'd65536;

        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_motor_angle    <= '0;
        i_motor_speed    <= '0;
        i_motor_current  <= '0;
        i_pole_angle_deg <= '0;
        i_angle_valid    <= 1'b0;
        i_out_stall      <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_MODE;
        i_cfg_data       <= '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: invalid angle straight after reset, then a pattern whose
        // filter sum is small but non-zero and must fall in the deadband
        send_tick(mk(0, 0, 0, 0, 1'b0));
        send_tick(mk(0, 32'h7FFF_FFFF, CUR_MAX, -57, 1'b1));
        send_tick(mk(0, 32'h8000_0000, -CUR_MAX, 57, 1'b1));
        send_tick(mk(CALM_SPAN, 0, 0, 0, 1'b1));
        send_tick(mk(-CALM_SPAN, 0, 0, 0, 1'b1));
        send_tick(mk(0, 0, 0, -57, 1'b1));
        send_tick(mk(0, 0, 0, 0, 1'b1));
        // pole angle extremes, then an ignored reading that repeats the last one
        send_tick(mk(0, 0, 0, 32'h7FFF_FFFF, 1'b1));
        send_tick(mk(0, 0, 0, 32'h8000_0000, 1'b1));
        send_tick(mk(0, 0, 0, 32'h5555_5555, 1'b0));
        for (int n = 1; n <= 3; n++) send_tick(mk(0, 0, 0, n * 327680, 1'b1));
        drain();

        // PD tracking on the reset gains: switch mode alone, upper data bits set
        cfg_val[CFG_MODE] = 32'hFFFF_0001;
        program_regs(CFG_MODE, CFG_MODE);
        send_tick(mk(CALM_SPAN, 32'h0001_0000, 0, 0, 1'b1));
        send_tick(mk(-CALM_SPAN, 32'hFFFF_0000, 0, 0, 1'b1));
        send_tick(mk(100000, 32'h7FFF_FFFF, 0, 0, 1'b1));
        send_tick(mk(-100000, 32'h8000_0000, 0, 0, 1'b1));
        send_tick(mk(0, 0, 0, 32'h0005_0000, 1'b1));
        drain();

        // Plain LQR torque, sender idles less than the receiver
        moderate_setting(MODE_TORQUE);
        program_regs(CFG_MODE, CFG_PD_KD);
        run_calm(470);
        drain();

        // PD tracking, idling swapped
        gap_pct   = 56;
        stall_pct = 31;
        moderate_setting(MODE_PD);
        program_regs(CFG_MODE, CFG_PD_KD);
        run_calm(470);
        drain();

        // Register extremes, no idling on either side
        gap_pct   = 0;
        stall_pct = 0;
        cfg_val[CFG_MODE]    = 32'hFFFF_FFFF;
        cfg_val[CFG_POS_OFF] = 32'h7FFF_FFFF;
        cfg_val[CFG_G_CPOS]  = 32'h7FFF_FFFF;
        cfg_val[CFG_G_CVEL]  = 32'h8000_0000;
        cfg_val[CFG_G_PANG]  = 32'h7FFF_FFFF;
        cfg_val[CFG_G_PRATE] = 32'h8000_0000;
        cfg_val[CFG_PD_KP]   = 32'h8000_0000;
        cfg_val[CFG_PD_KD]   = 32'h7FFF_FFFF;
        program_regs(CFG_MODE, CFG_PD_KD);
        run_calm(200);
        drain();

        cfg_val[CFG_MODE]    = 32'hFFFF_FFFE;
        cfg_val[CFG_POS_OFF] = 32'h8000_0000;
        cfg_val[CFG_G_CPOS]  = 32'h8000_0000;
        cfg_val[CFG_G_CVEL]  = 32'h7FFF_FFFF;
        cfg_val[CFG_G_PANG]  = 32'h8000_0000;
        cfg_val[CFG_G_PRATE] = 32'h7FFF_FFFF;
        cfg_val[CFG_PD_KP]   = 32'h7FFF_FFFF;
        cfg_val[CFG_PD_KD]   = 32'h8000_0000;
        program_regs(CFG_MODE, CFG_PD_KD);
        run_calm(150);
        drain();

        // Trip once (reset is never repeated), then check the latch holds under wild input
        moderate_setting(logic'($urandom_range(1)));
        program_regs(CFG_MODE, CFG_PD_KD);
        run_calm(20);
        plan = t_trip_plan'($urandom_range(2));
        t = calm_tick();
        if (plan != TRIP_BY_POSITION)
            t.motor_current = $urandom_range(1) ? CUR_MAX + 1 : -(CUR_MAX + 1);
        if (plan != TRIP_BY_CURRENT)
            t.motor_angle = (cur_offset >= 0) ? 32'(cur_offset - (CALM_SPAN + 1))
                                              : 32'(cur_offset + (CALM_SPAN + 1));
        send_tick(t);
        run_calm(2);
        send_tick(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        send_tick(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
        for (int n = 0; n < 60; n++)
            send_tick(mk($urandom, $urandom, $urandom, $urandom, logic'($urandom_range(1))));
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        case (plan)
            TRIP_BY_CURRENT:  plan_name = "over-current";
            TRIP_BY_POSITION: plan_name = "cart over-travel";
            default:          plan_name = "simultaneous over-current and over-travel";
        endcase
        fails = sb.mismatches + sb.pending();
        $display("Checked %0d control ticks: reset defaults, torque and PD modes, register",
                 sb.checked);
        $display("extremes and idle mixes, ending in a latched %s trip; %0d mismatches, %0d missing",
                 plan_name, sb.mismatches, sb.pending());
        if (fails == 0) begin
            $display("lqr_balance_controller_step verification clean");
        end else begin
            $display("lqr_balance_controller_step verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/lqrbc_pkg.sv
design/lqrbc_ram.sv
design/lqr_balance_controller_step.sv
test/tb_top.sv
